### rtl/core/matrix_parity_error_locator_core_assert.svh
// Assertion macros shared by the matrix parity error locator RTL.
`ifndef MATRIX_PARITY_ERROR_LOCATOR_CORE_ASSERT_SVH
`define MATRIX_PARITY_ERROR_LOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define MPEL_ASSERT(lbl, clock, rstn, prop) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (prop)) \
		else $error("mpel assertion failed");
// Check a property on every rising clock edge, reset included.
`define MPEL_ASSERT_ALWAYS(lbl, clock, prop) \
	lbl: assert property (@(posedge clock) (prop)) \
		else $error("mpel assertion failed");
`else
`define MPEL_ASSERT(lbl, clock, rstn, prop)
`define MPEL_ASSERT_ALWAYS(lbl, clock, prop)
`endif

`endif

### rtl/core/mpel_pkg.sv
// Package with the shared types and constants of the matrix parity error locator.
`timescale 1ns / 1ps
package mpel_pkg;

	// Width of the size register and of the reported row and column numbers.
	localparam int CFG_W = 8;
	localparam int OUT_W = 8;

	// Odd row counter saturates here.
	localparam logic [1:0] ODD_SAT = 2'd2;

	typedef enum logic [1:0] {
		VERDICT_EVEN    = 2'd0,
		VERDICT_FLIP    = 2'd1,
		VERDICT_CORRUPT = 2'd2
	} verdict_t;

	typedef struct packed {
		verdict_t         verdict;
		logic [OUT_W-1:0] flip_row;
		logic [OUT_W-1:0] flip_col;
	} result_t;

endpackage

### rtl/core/mpel_if.sv
// Channel interfaces: matrix cell stream, size configuration and verdict results.
`timescale 1ns / 1ps

interface mpel_cell_if ();
	logic valid;
	logic ready;
	logic cell_bit;

	modport source (output valid, output cell_bit, input ready);
	modport sink (input valid, input cell_bit, output ready);
endinterface

interface mpel_cfg_if import mpel_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mpel_res_if import mpel_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       verdict;
	logic [OUT_W-1:0] flip_row;
	logic [OUT_W-1:0] flip_col;

	modport source (output valid, output verdict, output flip_row, output flip_col,
		input ready);
	modport sink (input valid, input verdict, input flip_row, input flip_col,
		output ready);
endinterface

### rtl/core/mpel_front.sv
// Front end: accumulates row and column parities per item and classifies each matrix.
`timescale 1ns / 1ps
module mpel_front import mpel_pkg::*; #(
	parameter int MAX_SIZE = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	mpel_cell_if.sink        stream,
	mpel_cfg_if.sink         cfg,
	input  logic             q_full,
	output logic             push,
	output result_t          entry
);

	localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int CW = $clog2(MAX_SIZE + 1);
	localparam int EW = CW + CFG_W;
	localparam int XW = ((IW > OUT_W) ? IW : OUT_W) + 1;

	logic [IW-1:0]       size_m1_q;
	logic [IW-1:0]       col_q;
	logic [IW-1:0]       row_q;
	logic                rpar_q;
	logic [MAX_SIZE-1:0] cpar_q;
	logic [1:0]          orc_q;
	logic [IW-1:0]       ori_q;
	logic [CW-1:0]       occ_q;
	logic [IW-1:0]       ocx_q;

	logic                fire;
	logic                cfg_fire;
	logic                bit_in;
	logic                cur;
	logic                col_end;
	logic                mat_end;
	logic                rp_n;
	logic [1:0]          orc_n;
	logic [IW-1:0]       ori_n;
	logic [CW-1:0]       occ_n;
	logic [IW-1:0]       ocx_n;
	logic [EW-1:0]       cfg_ext;
	logic [IW-1:0]       cfg_m1;
	logic [XW-1:0]       row_num;
	logic [XW-1:0]       col_num;

	// Stall only when the closing item of a matrix has no queue slot.
	assign stream.ready = !(mat_end && q_full);
	assign cfg.ready    = 1'b1;
	assign fire         = stream.valid && stream.ready;
	assign cfg_fire     = cfg.valid && cfg.ready;
	assign push         = fire && mat_end;

	// Clamp the written size into one to MAX_SIZE, kept as size minus one.
	always_comb begin
		cfg_ext = EW'(cfg.data);
		if (cfg_ext == '0) begin
			cfg_m1 = '0;
		end else if (cfg_ext > EW'(MAX_SIZE)) begin
			cfg_m1 = IW'(MAX_SIZE - 1);
		end else begin
			cfg_m1 = IW'(cfg_ext - EW'(1));
		end
	end

	// Next parity bookkeeping for the item on the input.
	always_comb begin
		bit_in  = stream.cell_bit;
		cur     = cpar_q[col_q];
		col_end = (col_q == size_m1_q);
		mat_end = col_end && (row_q == size_m1_q);
		rp_n    = rpar_q ^ bit_in;
		occ_n   = occ_q;
		ocx_n   = ocx_q;
		if (bit_in) begin
			occ_n = cur ? (occ_q - CW'(1)) : (occ_q + CW'(1));
			ocx_n = ocx_q ^ col_q;
		end
		orc_n = orc_q;
		ori_n = ori_q;
		if (col_end && rp_n) begin
			ori_n = row_q;
			if (orc_q != ODD_SAT) begin
				orc_n = orc_q + 2'd1;
			end
		end
	end

	// Judge the finished matrix; the lone odd column is the xor of odd column indexes.
	always_comb begin
		row_num = XW'(ori_n) + XW'(1);
		col_num = XW'(ocx_n) + XW'(1);
		entry   = '{verdict: VERDICT_CORRUPT, flip_row: '0, flip_col: '0};
		priority if (orc_n == 2'd0 && occ_n == '0) begin
			entry.verdict = VERDICT_EVEN;
		end else if (orc_n == 2'd1 && occ_n == CW'(1)) begin
			entry.verdict  = VERDICT_FLIP;
			entry.flip_row = row_num[OUT_W-1:0];
			entry.flip_col = col_num[OUT_W-1:0];
		end else begin
			entry.verdict = VERDICT_CORRUPT;
		end
	end

	// Advance positions and parities; clear on a size write or at the end of a matrix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_m1_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			rpar_q    <= 1'b0;
			cpar_q    <= '0;
			orc_q     <= '0;
			ori_q     <= '0;
			occ_q     <= '0;
			ocx_q     <= '0;
		end else if (cfg_fire || push) begin
			if (cfg_fire) begin
				size_m1_q <= cfg_m1;
			end
			col_q  <= '0;
			row_q  <= '0;
			rpar_q <= 1'b0;
			cpar_q <= '0;
			orc_q  <= '0;
			ori_q  <= '0;
			occ_q  <= '0;
			ocx_q  <= '0;
		end else if (fire) begin
			cpar_q[col_q] <= cur ^ bit_in;
			col_q         <= col_end ? '0 : (col_q + IW'(1));
			row_q         <= col_end ? (row_q + IW'(1)) : row_q;
			rpar_q        <= col_end ? 1'b0 : rp_n;
			orc_q         <= orc_n;
			ori_q         <= ori_n;
			occ_q         <= occ_n;
			ocx_q         <= ocx_n;
		end
	end

endmodule

### rtl/core/mpel_queue.sv
// Back end: two-entry verdict queue whose head register drives the result channel.
`timescale 1ns / 1ps
module mpel_queue import mpel_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  result_t   entry,
	output logic      full,
	mpel_res_if.source res
);

	result_t    mem_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       pop;

	assign full         = (cnt_q == 2'd2);
	assign res.valid    = (cnt_q != 2'd0);
	assign res.verdict  = mem_q[rd_q].verdict;
	assign res.flip_row = mem_q[rd_q].flip_row;
	assign res.flip_col = mem_q[rd_q].flip_col;
	assign pop          = res.valid && res.ready;

	// Store pushed items.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= entry;
		end
	end

	// Track pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/matrix_parity_error_locator_core.sv
// Top level of the two-dimensional parity error locator.
//
// Usage: the size register is written on the cfg channel (8 bits, 0 reads as 1,
// values above MAX_SIZE clamp to MAX_SIZE); a write restarts the current matrix.
// Matrix bits then arrive on the stream channel, one item per cycle, row-major.
// After the last bit of an n x n matrix one item leaves on the res channel:
// verdict even, flip (with 1-based flip_row and flip_col) or corrupt.
// Throughput is one cell item per cycle, set by the single xor update of the
// row parity and the selected column parity bit in the front end.
// The verdict of the closing cell item is registered in the two-entry verdict
// queue, whose head register drives res.
// When res stalls, cells keep flowing; only the closing item of a matrix waits
// while both queue entries are occupied.
// Reset (arst_n low) sets the size to 1 and clears all parity state and the
// queue; no clearing pass is needed afterwards.
`timescale 1ns / 1ps
`include "matrix_parity_error_locator_core_assert.svh"
module matrix_parity_error_locator_core import mpel_pkg::*; #(
	parameter int MAX_SIZE = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	mpel_cell_if.sink  stream,
	mpel_cfg_if.sink   cfg,
	mpel_res_if.source res
);

	logic    push;
	logic    q_full;
	result_t entry;

	mpel_front #(
		.MAX_SIZE(MAX_SIZE)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.stream(stream),
		.cfg   (cfg),
		.q_full(q_full),
		.push  (push),
		.entry (entry)
	);

	mpel_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.entry (entry),
		.full  (q_full),
		.res   (res)
	);

	// Never push into a full queue.
	`MPEL_ASSERT(a_no_overflow, clk, arst_n, push |-> !q_full)
	// After a push, res.valid is high on the next cycle.
	`MPEL_ASSERT(a_push_shows, clk, arst_n, push |=> res.valid)
	// Row and column numbers are zero unless a single flip is reported.
	`MPEL_ASSERT(a_zero_pos, clk, arst_n,
		(res.valid && res.verdict != VERDICT_FLIP) |-> (res.flip_row == '0 && res.flip_col == '0))

endmodule
